@@ sv/swfp_pkg.sv @@
// ----------------------------------------------------------------------------
// swfp_pkg: shared types and constants for the scale weight frame parser
// Character codes, result codes and the record passed down the digit chain.
// ----------------------------------------------------------------------------
package swfp_pkg;

	localparam int IN_W     = 8;
	localparam int OUT_W    = 40;
	localparam int WIN_LEN  = 17;
	localparam int N_DIGITS = 7;
	localparam int MAG_W    = 24;
	localparam int FRAC_W   = 3;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = ",";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_POINT = ".";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";

	localparam logic [15:0] PAIR_OL = "OL";
	localparam logic [15:0] PAIR_UL = "UL";
	localparam logic [15:0] PAIR_ST = "ST";
	localparam logic [15:0] PAIR_US = "US";
	localparam logic [15:0] PAIR_NT = "NT";
	localparam logic [15:0] PAIR_GS = "GS";
	localparam logic [15:0] PAIR_KG = "kg";
	localparam logic [15:0] PAIR_TN = "-t";
	localparam logic [15:0] PAIR_GR = "-g";

	typedef enum logic [2:0] {
		STATUS_OK        = 3'd0,
		STATUS_BAD_COMMA = 3'd1,
		STATUS_BAD_STAB  = 3'd2,
		STATUS_BAD_KIND  = 3'd3,
		STATUS_BAD_SIGN  = 3'd4,
		STATUS_BAD_DIGIT = 3'd5,
		STATUS_BAD_UNIT  = 3'd6
	} status_t;

	localparam logic [1:0] STAB_OVER   = 2'd0;
	localparam logic [1:0] STAB_UNDER  = 2'd1;
	localparam logic [1:0] STAB_STABLE = 2'd2;
	localparam logic [1:0] STAB_MOVING = 2'd3;

	localparam logic KIND_NET   = 1'b0;
	localparam logic KIND_GROSS = 1'b1;

	localparam logic [1:0] UNIT_KG = 2'd0;
	localparam logic [1:0] UNIT_TN = 2'd1;
	localparam logic [1:0] UNIT_GR = 2'd2;

	// One frame on its way down the digit chain. Digit slot 0 is the next
	// one to be folded in; slots shift down by one per cell.
	typedef struct packed {
		status_t                      status;
		logic [1:0]                   stab;
		logic                         kind;
		logic                         neg;
		logic [1:0]                   unit;
		logic                         in_frac;
		logic [FRAC_W-1:0]            frac;
		logic [MAG_W-1:0]             mag;
		logic [N_DIGITS-1:0]          is_dig;
		logic [N_DIGITS-1:0][3:0]     digit;
	} acc_t;

endpackage

@@ sv/scale_weight_frame_parser_core.sv @@
// ----------------------------------------------------------------------------
// scale_weight_frame_parser_core: frame parser for a serial scale
// Keeps the last 17 received bytes and decodes a weight frame on CR LF.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; s_tready drops only when the result chain
//   is full and the output register is stalled.
// Path: the accepting edge of the LF loads the decode register, then the
//   frame passes through the seven digit cells and the output register to
//   m_tvalid; a stall downstream can hold it in any of them.
// Reset: arst_n clears the byte window to zero and empties the chain.
// ----------------------------------------------------------------------------
module scale_weight_frame_parser_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [swfp_pkg::IN_W-1:0]  s_tdata,   // [7:0] rx_byte
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [2:0] status, [4:3] stability, [5] weight_kind, [6] negative,
	// [30:7] magnitude, [33:31] fraction_digits, [35:34] unit_code, rest zero
	output logic [swfp_pkg::OUT_W-1:0] m_tdata
);
	import swfp_pkg::*;

	// ---------------------------------------------------------------- window
	// win[0] is the oldest byte, win[WIN_LEN-1] the newest.
	logic [7:0] win [WIN_LEN];
	logic       accept;
	logic       trigger;

	assign accept  = s_tvalid && s_tready;
	assign trigger = (s_tdata == CH_LF) && (win[WIN_LEN-1] == CH_CR);

	genvar gi;
	generate
		for (gi = 0; gi < WIN_LEN; gi++) begin : g_win
			logic [7:0] d_in;
			if (gi == WIN_LEN - 1) begin : g_new
				assign d_in = s_tdata;
			end else begin : g_old
				assign d_in = win[gi+1];
			end
			swfp_byte_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (accept),
				.d      (d_in),
				.q      (win[gi])
			);
		end
	endgenerate

	// ---------------------------------------------------------------- decode
	// Check the frame fields in the window; the first failing check in the
	// order commas, stability, kind, sign, digits, unit sets the status.
	acc_t dec;
	logic stab_ok, kind_ok, sign_ok, digits_ok, unit_ok;

	always_comb begin
		dec         = '0;
		dec.status  = STATUS_OK;
		stab_ok     = 1'b1;
		kind_ok     = 1'b1;
		sign_ok     = 1'b1;
		digits_ok   = 1'b1;
		unit_ok     = 1'b1;

		unique case ({win[0], win[1]})
			PAIR_OL: dec.stab = STAB_OVER;
			PAIR_UL: dec.stab = STAB_UNDER;
			PAIR_ST: dec.stab = STAB_STABLE;
			PAIR_US: dec.stab = STAB_MOVING;
			default: stab_ok  = 1'b0;
		endcase

		unique case ({win[3], win[4]})
			PAIR_NT: dec.kind = KIND_NET;
			PAIR_GS: dec.kind = KIND_GROSS;
			default: kind_ok  = 1'b0;
		endcase

		unique case (win[6]) inside
			CH_PLUS, CH_SPACE: dec.neg     = 1'b0;
			CH_MINUS:          dec.neg     = 1'b1;
			CH_POINT:          dec.in_frac = 1'b1;
			default:           sign_ok     = 1'b0;
		endcase

		for (int k = 0; k < N_DIGITS; k++) begin
			dec.is_dig[k] = (win[7+k] >= CH_ZERO) && (win[7+k] <= CH_NINE);
			dec.digit[k]  = 4'(win[7+k] - CH_ZERO);
			if (!dec.is_dig[k] && (win[7+k] != CH_POINT)) begin
				digits_ok = 1'b0;
			end
		end

		unique case ({win[14], win[15]})
			PAIR_KG: dec.unit = UNIT_KG;
			PAIR_TN: dec.unit = UNIT_TN;
			PAIR_GR: dec.unit = UNIT_GR;
			default: unit_ok  = 1'b0;
		endcase

		if (win[2] != CH_COMMA || win[5] != CH_COMMA) dec.status = STATUS_BAD_COMMA;
		else if (!stab_ok)                             dec.status = STATUS_BAD_STAB;
		else if (!kind_ok)                             dec.status = STATUS_BAD_KIND;
		else if (!sign_ok)                             dec.status = STATUS_BAD_SIGN;
		else if (!digits_ok)                           dec.status = STATUS_BAD_DIGIT;
		else if (!unit_ok)                             dec.status = STATUS_BAD_UNIT;
	end

	// ---------------------------------------------------------- flow control
	// Each stage advances when it is empty or its successor advances, so
	// bubbles collapse and bytes keep flowing while a result waits, until the chain is full.
	logic                en_out;
	logic                en_s1;
	logic [N_DIGITS-1:0] en_c;
	logic [N_DIGITS-1:0] v_c;
	acc_t                acc_c [N_DIGITS];

	assign en_out = !m_tvalid || m_tready;

	generate
		for (gi = 0; gi < N_DIGITS; gi++) begin : g_en
			if (gi == N_DIGITS - 1) begin : g_last
				assign en_c[gi] = !v_c[gi] || en_out;
			end else begin : g_mid
				assign en_c[gi] = !v_c[gi] || en_c[gi+1];
			end
		end
	endgenerate

	// ------------------------------------------------------- decode register
	logic v_s1;
	acc_t acc_s1;

	assign en_s1    = !v_s1 || en_c[0];
	assign s_tready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= accept && trigger;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			acc_s1 <= dec;
		end
	end

	// ------------------------------------------------------------ digit chain
	generate
		for (gi = 0; gi < N_DIGITS; gi++) begin : g_mac
			logic vin;
			acc_t din;
			if (gi == 0) begin : g_first
				assign vin = v_s1;
				assign din = acc_s1;
			end else begin : g_next
				assign vin = v_c[gi-1];
				assign din = acc_c[gi-1];
			end
			swfp_mac_cell u_mac (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (en_c[gi]),
				.vin    (vin),
				.din    (din),
				.vout   (v_c[gi]),
				.dout   (acc_c[gi])
			);
		end
	endgenerate

	// ------------------------------------------------------- output register
	// Drop every field but the status on a failed frame.
	acc_t                 fin;
	logic [OUT_W-1:0]     res_d;
	logic [OUT_W-1:0]     res_q;
	logic                 out_v_q;

	assign fin = acc_c[N_DIGITS-1];

	always_comb begin
		res_d       = '0;
		res_d[2:0]  = fin.status;
		if (fin.status == STATUS_OK) begin
			res_d[4:3]   = fin.stab;
			res_d[5]     = fin.kind;
			res_d[6]     = fin.neg;
			res_d[30:7]  = fin.mag;
			res_d[33:31] = fin.frac;
			res_d[35:34] = fin.unit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_c[N_DIGITS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = res_q;

	// ------------------------------------------------------------ assertions
	a_frame_captured: assert property (@(posedge clk) disable iff (!arst_n)
		accept && trigger |=> v_s1)
		else $error("CR LF frame not captured into decode register");

	a_fail_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] != STATUS_OK) |-> (m_tdata[OUT_W-1:3] == '0))
		else $error("failed frame carries nonzero fields");

	a_mag_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == STATUS_OK) |-> (m_tdata[30:7] <= 24'd9999999))
		else $error("magnitude out of range");

	a_unit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[2:0] == STATUS_OK) |-> (m_tdata[35:34] != 2'd3))
		else $error("unit code invalid on ok frame");

endmodule

@@ sv/swfp_byte_cell.sv @@
// ----------------------------------------------------------------------------
// swfp_byte_cell: one byte of the receive window
// Load the neighbor's byte on every accepted request; clear at reset.
// ----------------------------------------------------------------------------
module swfp_byte_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] d,
	output logic [7:0] q
);

	logic [7:0] byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (en) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

@@ sv/swfp_mac_cell.sv @@
// ----------------------------------------------------------------------------
// swfp_mac_cell: one step of the weight digit chain
// Fold the next digit into the magnitude, track the point, pass it on.
// ----------------------------------------------------------------------------
module swfp_mac_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vin,
	input  swfp_pkg::acc_t din,
	output logic          vout,
	output swfp_pkg::acc_t dout
);
	import swfp_pkg::*;

	logic valid_q;
	acc_t acc_q;
	acc_t acc_d;

	always_comb begin
		acc_d        = din;
		acc_d.digit  = din.digit >> 4;
		acc_d.is_dig = din.is_dig >> 1;
		if (din.is_dig[0]) begin
			acc_d.mag = (din.mag << 3) + (din.mag << 1) + MAG_W'(din.digit[0]);
			if (din.in_frac) begin
				acc_d.frac = din.frac + FRAC_W'(1);
			end
		end else begin
			// not a digit: a point (bad characters are already flagged)
			acc_d.in_frac = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			acc_q <= acc_d;
		end
	end

	assign vout = valid_q;
	assign dout = acc_q;

endmodule

@@ test/swfp_frame_checker.sv @@
// ----------------------------------------------------------------------------
// swfp_frame_checker: scoreboard for the scale weight frame parser
// Mirrors the byte window, decodes each CR LF frame and compares the results.
// ----------------------------------------------------------------------------
module swfp_frame_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [swfp_pkg::IN_W-1:0]  s_tdata,
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	input  logic [swfp_pkg::OUT_W-1:0] m_tdata,
	output int                         mismatch_count,
	output int                         frames_in_flight,
	output int                         frames_decoded,
	output int                         frames_good
);
	timeunit 1ns;
	timeprecision 1ps;
	import swfp_pkg::*;

	// Result layout, lowest field last.
	typedef struct packed {
		logic [3:0]        pad;
		logic [1:0]        unit;
		logic [FRAC_W-1:0] frac;
		logic [MAG_W-1:0]  mag;
		logic              neg;
		logic              kind;
		logic [1:0]        stab;
		status_t           status;
	} weight_report_t;

	// Index 0 is the oldest byte, index WIN_LEN-1 the newest.
	logic [WIN_LEN-1:0][7:0] rx_hist;
	weight_report_t          report_q[$];
	int                      n_mismatch = 0;
	int                      n_decoded  = 0;
	int                      n_good     = 0;
	int                      n_results  = 0;

	assign mismatch_count   = n_mismatch;
	assign frames_in_flight = report_q.size();
	assign frames_decoded   = n_decoded;
	assign frames_good      = n_good;

	function automatic weight_report_t decode_frame(input logic [WIN_LEN-1:0][7:0] w);
		weight_report_t r;
		logic [1:0]        stab;
		logic              kind;
		logic              neg;
		logic              point_seen;
		logic [MAG_W-1:0]  mag;
		logic [FRAC_W-1:0] frac;
		r          = '0;
		neg        = 1'b0;
		point_seen = 1'b0;
		mag        = '0;
		frac       = '0;
		if (w[2] != CH_COMMA || w[5] != CH_COMMA) begin
			r.status = STATUS_BAD_COMMA;
			return r;
		end
		case ({w[0], w[1]})
			PAIR_OL: stab = STAB_OVER;
			PAIR_UL: stab = STAB_UNDER;
			PAIR_ST: stab = STAB_STABLE;
			PAIR_US: stab = STAB_MOVING;
			default: begin
				r.status = STATUS_BAD_STAB;
				return r;
			end
		endcase
		case ({w[3], w[4]})
			PAIR_NT: kind = KIND_NET;
			PAIR_GS: kind = KIND_GROSS;
			default: begin
				r.status = STATUS_BAD_KIND;
				return r;
			end
		endcase
		// A point in the sign slot reads as positive and opens the fraction.
		case (w[6]) inside
			CH_PLUS, CH_SPACE: neg = 1'b0;
			CH_MINUS:          neg = 1'b1;
			CH_POINT:          point_seen = 1'b1;
			default: begin
				r.status = STATUS_BAD_SIGN;
				return r;
			end
		endcase
		for (int k = 7; k < 7 + N_DIGITS; k++) begin
			if (w[k] >= CH_ZERO && w[k] <= CH_NINE) begin
				mag = MAG_W'(mag * 10) + MAG_W'(w[k] - CH_ZERO);
				if (point_seen)
					frac = frac + 1'b1;
			end else if (w[k] == CH_POINT) begin
				point_seen = 1'b1;
			end else begin
				r.status = STATUS_BAD_DIGIT;
				return r;
			end
		end
		case ({w[14], w[15]})
			PAIR_KG: r.unit = UNIT_KG;
			PAIR_TN: r.unit = UNIT_TN;
			PAIR_GR: r.unit = UNIT_GR;
			default: begin
				r.status = STATUS_BAD_UNIT;
				r.unit   = '0;
				return r;
			end
		endcase
		r.status = STATUS_OK;
		r.stab   = stab;
		r.kind   = kind;
		r.neg    = neg;
		r.mag    = mag;
		r.frac   = frac;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		weight_report_t got;
		weight_report_t want;
		if (!arst_n) begin
			rx_hist <= '0;
			report_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got = weight_report_t'(m_tdata);
				n_results++;
				if (report_q.size() == 0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("%t: result %0d arrived with no frame pending: %h",
							$realtime, n_results, m_tdata);
				end else begin
					want = report_q.pop_front();
					if (got.status !== want.status || got.stab !== want.stab ||
						got.kind !== want.kind || got.neg !== want.neg ||
						got.mag !== want.mag || got.frac !== want.frac ||
						got.unit !== want.unit || got.pad !== want.pad) begin
						n_mismatch++;
						if (n_mismatch <= 10) begin
							$display("%t: result %0d mismatch", $realtime, n_results);
							$display({"  expected status=%0d stab=%0d kind=%0d neg=%0d",
								" mag=%0d frac=%0d unit=%0d pad=%h"},
								want.status, want.stab, want.kind, want.neg,
								want.mag, want.frac, want.unit, want.pad);
							$display({"  actual   status=%0d stab=%0d kind=%0d neg=%0d",
								" mag=%0d frac=%0d unit=%0d pad=%h"},
								got.status, got.stab, got.kind, got.neg,
								got.mag, got.frac, got.unit, got.pad);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				// Decode only when LF lands right behind a CR.
				if (s_tdata == CH_LF && rx_hist[WIN_LEN-1] == CH_CR) begin
					want = decode_frame(rx_hist);
					report_q.push_back(want);
					n_decoded++;
					if (want.status == STATUS_OK)
						n_good++;
				end
				rx_hist <= {s_tdata, rx_hist[WIN_LEN-1:1]};
			end
		end
	end

endmodule

@@ test/scale_weight_frame_parser_core_test.sv @@
// ----------------------------------------------------------------------------
// scale_weight_frame_parser_core_test: stimulus and verdict for the frame parser
// Drives directed and random serial byte streams with idle gaps on both sides.
// ----------------------------------------------------------------------------
module scale_weight_frame_parser_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import swfp_pkg::*;

	// Valid code tables, entry 0 in the lowest slot.
	localparam logic [3:0][15:0] STAB_PAIRS = {PAIR_US, PAIR_ST, PAIR_UL, PAIR_OL};
	localparam logic [1:0][15:0] KIND_PAIRS = {PAIR_GS, PAIR_NT};
	localparam logic [2:0][15:0] UNIT_PAIRS = {PAIR_GR, PAIR_TN, PAIR_KG};
	localparam logic [3:0][7:0]  SIGN_CHARS = {CH_POINT, CH_MINUS, CH_SPACE, CH_PLUS};
	// Characters that are valid somewhere in a frame; used for near-miss corruption.
	localparam logic [127:0]     NEAR_MISS  = "OLUSTNGkg-t,.+ 5";

	localparam int RANDOM_BYTES = 600;
	localparam int RANDOM_FRAMES = 30;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	int mismatch_count;
	int frames_in_flight;
	int frames_decoded;
	int frames_good;
	int n_bytes = 0;
	bit calm    = 1'b0;

	scale_weight_frame_parser_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	swfp_frame_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.mismatch_count   (mismatch_count),
		.frames_in_flight (frames_in_flight),
		.frames_decoded   (frames_decoded),
		.frames_good      (frames_good)
	);

	always #2 clk = ~clk;

	// Idle length: mostly none or short, now and then a long stretch.
	function automatic int idle_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 85)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one byte, starting and ending on a falling edge; hold it until accepted.
	task automatic push_byte(input logic [7:0] b);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		n_bytes++;
		@(negedge clk);
	endtask

	// Drop valid and hold off until every pending frame result is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (frames_in_flight != 0)
			@(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	// Send a 16-character frame body followed by CR LF.
	task automatic send_line(input string body);
		for (int i = 0; i < body.len(); i++)
			push_byte(body[i]);
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	// Build a well-formed frame with random content, then maybe damage one byte.
	task automatic send_random_frame();
		logic [7:0] body [16];
		int         p;
		int         q;
		int         n;
		{body[0], body[1]} = STAB_PAIRS[2'($urandom_range(0, 3))];
		body[2]            = CH_COMMA;
		{body[3], body[4]} = KIND_PAIRS[1'($urandom_range(0, 1))];
		body[5]            = CH_COMMA;
		body[6]            = SIGN_CHARS[2'($urandom_range(0, 3))];
		for (int k = 7; k < 14; k++)
			body[k] = ($urandom_range(0, 99) < 15) ? CH_POINT
				: 8'(CH_ZERO + $urandom_range(0, 9));
		{body[14], body[15]} = UNIT_PAIRS[2'($urandom_range(0, 2))];

		p = $urandom_range(0, 99);
		if (p < 20)
			body[4'($urandom_range(0, 15))] = 8'($urandom_range(0, 255));
		else if (p < 35)
			body[4'($urandom_range(0, 15))] =
				NEAR_MISS[{4'($urandom_range(0, 15)), 3'b000} +: 8];

		// Leading noise: stray bytes, or a bare CR LF on a stale window.
		p = $urandom_range(0, 99);
		if (p < 20) begin
			n = $urandom_range(1, 6);
			repeat (n) push_byte(8'($urandom_range(0, 255)));
		end else if (p < 25) begin
			push_byte(CH_CR);
			push_byte(CH_LF);
		end

		foreach (body[i])
			push_byte(body[i]);

		// Terminator: usually CR LF, sometimes broken.
		q = $urandom_range(0, 99);
		if (q < 85) begin
			push_byte(CH_CR);
			push_byte(CH_LF);
		end else if (q < 92) begin
			push_byte(CH_CR);
			push_byte(8'($urandom_range(0, 255)));
		end else begin
			push_byte(CH_LF);
		end

		// Trailing: a repeated LF gives nothing, a second CR LF rechecks the window.
		q = $urandom_range(0, 99);
		if (q < 10) begin
			push_byte(CH_LF);
		end else if (q < 18) begin
			push_byte(CH_CR);
			push_byte(CH_LF);
		end
	endtask

	// Receiver side: random stalls with occasional long stretches of no stall.
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 99) == 0) begin
				m_tready <= 1'b1;
				repeat (100) @(negedge clk);
			end else begin
				stall = idle_len();
				if (stall == 0) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					repeat (stall - 1) @(negedge clk);
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// CR LF on the cleared window: zeros fail the comma check.
		push_byte(CH_CR);
		push_byte(CH_LF);

		// Good frames across every code, the extremes and the odd point cases.
		send_line("ST,NT,+0012.50kg");
		send_line("OL,GS,-9999999-t");
		send_line("UL,NT, 0000000-g");
		send_line("US,GS,.1234567kg");
		send_line("ST,NT,-000.000kg");
		send_line("ST,NT,+1.2.3.4kg");
		send_line("ST,NT,+.......kg");
		send_line("ST,GS,+1234567kg");

		// After a frame: a lone LF gives nothing, another CR LF rechecks the window.
		push_byte(CH_LF);
		push_byte(CH_CR);
		push_byte(CH_LF);

		// One failure per check, then overlapping failures to test priority.
		send_line("ST;NT,+0012.50kg");
		send_line("ST,NT;+0012.50kg");
		send_line("st,NT,+0012.50kg");
		send_line("ST,NX,+0012.50kg");
		send_line("ST,NT,*0012.50kg");
		send_line("ST,NT,+00a2.50kg");
		send_line("ST,NT,+/000000kg");
		send_line("ST,NT,+000000:kg");
		send_line("ST,NT,+0012.50lb");
		send_line("ST,NT,+0012.50-k");
		send_line("XX;NT,*0012.50lb");
		send_line("XX,NX,*0012.50lb");

		// Hold off until the directed results are all back.
		drain();

		// Random frames until enough bytes have been sent and enough frames decoded.
		while (n_bytes < RANDOM_BYTES || frames_decoded < RANDOM_FRAMES) begin
			calm = ($urandom_range(0, 99) < 20);
			send_random_frame();
			if ($urandom_range(0, 9) == 0)
				drain();
		end
		calm = 1'b0;

		// Drain the pipe, then allow for any stray result past the latency.
		drain();
		repeat (20) @(negedge clk);

		$display("Sent %0d bytes; %0d frames decoded, %0d good and %0d rejected.",
			n_bytes, frames_decoded, frames_good, frames_decoded - frames_good);
		$display("Mismatches: %0d", mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("Timeout with %0d frame results still pending", frames_in_flight);
		$display("Verification failed");
		$finish;
	end

endmodule

@@ files.f @@
sv/swfp_pkg.sv
sv/swfp_byte_cell.sv
sv/swfp_mac_cell.sv
sv/scale_weight_frame_parser_core.sv
test/swfp_frame_checker.sv
test/scale_weight_frame_parser_core_test.sv
